// ===== sv/rmdu_pkg.sv =====
`default_nettype none
package rmdu_pkg;

  localparam int unsigned XLEN      = 64;
  localparam int unsigned DIV_CELLS = XLEN;
  localparam int unsigned MUL_DELAY = DIV_CELLS - 2;

  typedef enum logic [3:0] {
    OP_MUL    = 4'd0,
    OP_MULH   = 4'd1,
    OP_MULHSU = 4'd2,
    OP_MULHU  = 4'd3,
    OP_DIV    = 4'd4,
    OP_DIVU   = 4'd5,
    OP_REM    = 4'd6,
    OP_REMU   = 4'd7,
    OP_MULW   = 4'd8,
    OP_DIVW   = 4'd9,
    OP_DIVUW  = 4'd10,
    OP_REMW   = 4'd11,
    OP_REMUW  = 4'd12
  } opcode_e;

  // One divide step: partial remainder, dividend/quotient shift word, divisor
  typedef struct packed {
    logic            valid;
    logic [3:0]      op;
    logic            neg_q;
    logic            neg_r;
    logic [XLEN-1:0] rem;
    logic [XLEN-1:0] nq;
    logic [XLEN-1:0] dvs;
  } cell_t;

  function automatic logic [XLEN-1:0] sext32(input logic [XLEN-1:0] v);
    return {{(XLEN-32){v[31]}}, v[31:0]};
  endfunction

endpackage
`default_nettype wire

// ===== sv/rmdu_div_cell.sv =====
`default_nettype none
module rmdu_div_cell
  import rmdu_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  adv_i,
  input  wire cell_t cell_i,
  output cell_t      cell_o
);

  logic [XLEN:0]   trial;
  logic            ge;
  logic [XLEN:0]   diff;
  cell_t           cell_d;
  cell_t           cell_q;

  // Shift in the next dividend bit, try the subtract
  always_comb begin
    trial  = {cell_i.rem, cell_i.nq[XLEN-1]};
    ge     = trial >= {1'b0, cell_i.dvs};
    diff   = trial - {1'b0, cell_i.dvs};
    cell_d = cell_i;
    cell_d.rem = ge ? diff[XLEN-1:0] : trial[XLEN-1:0];
    cell_d.nq  = {cell_i.nq[XLEN-2:0], ge};
  end

  // Advance the item, clear under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (adv_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule
`default_nettype wire

// ===== sv/rmdu_mul.sv =====
`default_nettype none
module rmdu_mul
  import rmdu_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            adv_i,
  input  wire logic [3:0]      op_i,
  input  wire logic [XLEN-1:0] a_i,
  input  wire logic [XLEN-1:0] b_i,
  output logic [XLEN-1:0]      res_o
);

  logic [63:0]     ll_q, lh_q, hl_q, hh_q;
  logic [XLEN-1:0] a_q, b_q;
  logic [3:0]      op_q, op1_q;
  logic [127:0]    full_d, full_q;
  logic [XLEN-1:0] corr_d, corr_q;
  logic [XLEN-1:0] res_d, res_q;
  logic [XLEN-1:0] hi;

  // Stage 1: four 32x32 partial products
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ll_q <= 64'(a_i[31:0])  * 64'(b_i[31:0]);
      lh_q <= 64'(a_i[31:0])  * 64'(b_i[63:32]);
      hl_q <= 64'(a_i[63:32]) * 64'(b_i[31:0]);
      hh_q <= 64'(a_i[63:32]) * 64'(b_i[63:32]);
      a_q  <= a_i;
      b_q  <= b_i;
      op_q <= op_i;
    end
  end

  // Stage 2: sum the products, gather the signed corrections
  always_comb begin
    full_d = {64'd0, ll_q} + {32'd0, lh_q, 32'd0} + {32'd0, hl_q, 32'd0} + {hh_q, 64'd0};
    corr_d = (((op_q == OP_MULH) || (op_q == OP_MULHSU)) && a_q[XLEN-1]) ? b_q : '0;
    if ((op_q == OP_MULH) && b_q[XLEN-1]) begin
      corr_d = corr_d + a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      full_q <= full_d;
      corr_q <= corr_d;
      op1_q  <= op_q;
    end
  end

  // Stage 3: pick low, corrected high or word result
  always_comb begin
    hi = full_q[127:64] - corr_q;
    case (op1_q)
      OP_MUL:                       res_d = full_q[63:0];
      OP_MULH, OP_MULHSU, OP_MULHU: res_d = hi;
      OP_MULW:                      res_d = sext32(full_q[63:0]);
      default:                      res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule
`default_nettype wire

// ===== sv/rv64m_mul_div_unit.sv =====
`default_nettype none
// RV64M multiply/divide unit. Accepts one item per cycle and presents each result
// in order, after one input register, a chain of 64 divide cells producing one
// quotient bit each, and one output register. Multiplies run through a three-stage
// 32x32 partial-product pipeline and a delay line so every operation has the same
// latency. A stalled output holds the whole pipeline.
module rv64m_mul_div_unit
  import rmdu_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [3:0]  operation_i,
  input  wire logic [63:0] first_operand_i,
  input  wire logic [63:0] second_operand_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      result_value_o
);

  logic            adv;
  logic            is_word, is_signed;
  logic [XLEN-1:0] n_ext, d_ext, n_mag, d_mag;
  logic            nn, dn;
  cell_t           s0_d, s0_q;
  cell_t           chain [DIV_CELLS+1];
  logic [XLEN-1:0] mul_res;
  logic [XLEN-1:0] dly_q [MUL_DELAY];
  cell_t           last;
  logic [XLEN-1:0] quo, rmd, res_d, res_q;
  logic            out_valid_q;

  // Move everything whenever the output slot is free or being taken
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // Prepare divide operands: extend, take magnitudes, note result signs
  always_comb begin
    is_word   = (operation_i == OP_DIVW) || (operation_i == OP_DIVUW) ||
                (operation_i == OP_REMW) || (operation_i == OP_REMUW);
    is_signed = (operation_i == OP_DIV) || (operation_i == OP_REM) ||
                (operation_i == OP_DIVW) || (operation_i == OP_REMW);
    if (is_word) begin
      n_ext = is_signed ? sext32(first_operand_i)  : {32'd0, first_operand_i[31:0]};
      d_ext = is_signed ? sext32(second_operand_i) : {32'd0, second_operand_i[31:0]};
    end else begin
      n_ext = first_operand_i;
      d_ext = second_operand_i;
    end
    nn    = is_signed && n_ext[XLEN-1];
    dn    = is_signed && d_ext[XLEN-1];
    n_mag = nn ? (~n_ext + 1'b1) : n_ext;
    d_mag = dn ? (~d_ext + 1'b1) : d_ext;
    s0_d.valid = in_valid_i;
    s0_d.op    = operation_i;
    s0_d.neg_q = (nn ^ dn) && (d_ext != '0);
    s0_d.neg_r = nn;
    s0_d.rem   = '0;
    s0_d.nq    = n_mag;
    s0_d.dvs   = d_mag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q <= '0;
    end else if (adv) begin
      s0_q <= s0_d;
    end
  end

  // Divide chain, one quotient bit per cell
  assign chain[0] = s0_q;
  for (genvar k = 0; k < DIV_CELLS; k++) begin : g_cell
    rmdu_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .cell_i (chain[k]),
      .cell_o (chain[k+1])
    );
  end

  // Multiply pipeline
  rmdu_mul u_mul (
    .clk_i (clk_i),
    .adv_i (adv),
    .op_i  (operation_i),
    .a_i   (first_operand_i),
    .b_i   (second_operand_i),
    .res_o (mul_res)
  );

  // Delay multiply results to line up with the divide chain
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dly_q[0] <= mul_res;
      for (int j = 1; j < MUL_DELAY; j++) begin
        dly_q[j] <= dly_q[j-1];
      end
    end
  end

  // Apply signs and select the result
  always_comb begin
    last = chain[DIV_CELLS];
    quo  = last.neg_q ? (~last.nq + 1'b1)  : last.nq;
    rmd  = last.neg_r ? (~last.rem + 1'b1) : last.rem;
    case (last.op)
      OP_MUL, OP_MULH, OP_MULHSU, OP_MULHU, OP_MULW: res_d = dly_q[MUL_DELAY-1];
      OP_DIV, OP_DIVU:   res_d = quo;
      OP_REM, OP_REMU:   res_d = rmd;
      OP_DIVW, OP_DIVUW: res_d = sext32(quo);
      OP_REMW, OP_REMUW: res_d = sext32(rmd);
      default:           res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = res_q;

  // An accepted item enters the first stage
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> s0_q.valid)
    else $error("accepted item missing from first stage");

  // A stalled output freezes the end of the chain
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(chain[DIV_CELLS].valid))
    else $error("divide chain moved during stall");

  // A finished item reaches the output
  a_last_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chain[DIV_CELLS].valid && in_ready_o) |=> out_valid_o)
    else $error("item lost at output stage");

endmodule
`default_nettype wire
